FILE: src/svn_pkg.sv
package svn_pkg;

	// Component format
	localparam int CompW = 16;
	localparam int FracB = 14;

	// Root digits: q lies in [0, 2^FracB]
	localparam int QW = FracB + 1;
	localparam int BitIdxW = $clog2(QW);

	// Sum of squares and working widths
	localparam int SqW = 2 * CompW;
	localparam int SumW = 2 * CompW;
	localparam int AccW = SumW + 2 * QW + 6;

	localparam int TolW = 32;
	localparam logic [TolW-1:0] TolReset = TolW'(1);

	// Status codes
	localparam logic [1:0] CodeScaled = 2'd0;
	localparam logic [1:0] CodeUnit   = 2'd1;
	localparam logic [1:0] CodeZeroed = 2'd2;

	// Per-component state of the digit search
	typedef struct packed {
		logic [QW-1:0]          q;
		logic signed [AccW-1:0] a;   // (2q-1)^2 * s
		logic signed [AccW-1:0] b;   // (2q-1) * s
		logic signed [AccW-1:0] r;   // 4 * mag^2 * 2^(2F)
	} lane_t;

	typedef struct packed {
		logic [1:0]                code;
		logic [2:0]                neg;
		logic [2:0][CompW-1:0]     raw;
		logic [SumW-1:0]           s;
		lane_t [2:0]               lane;
	} stage_t;

endpackage

FILE: src/svn_if.sv
interface svn_vec_if;
	import svn_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [CompW-1:0] vec_x;
	logic signed [CompW-1:0] vec_y;
	logic signed [CompW-1:0] vec_z;
	modport source (output valid, vec_x, vec_y, vec_z, input ready);
	modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface svn_norm_if;
	import svn_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [CompW-1:0] norm_x;
	logic signed [CompW-1:0] norm_y;
	logic signed [CompW-1:0] norm_z;
	logic [1:0]              case_code;
	modport source (output valid, norm_x, norm_y, norm_z, case_code, input ready);
	modport sink (input valid, norm_x, norm_y, norm_z, case_code, output ready);
endinterface

interface svn_cfg_if;
	import svn_pkg::*;
	logic            valid;
	logic            ready;
	logic [TolW-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: src/svn_front.sv
module svn_front
	import svn_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [CompW-1:0]    in_x,
	input  logic [CompW-1:0]    in_y,
	input  logic [CompW-1:0]    in_z,
	input  logic [TolW-1:0]     tolerance,
	output logic                out_valid,
	output stage_t              out_stage
);

	logic                  valid_s1;
	logic [2:0][CompW-1:0] raw_s1;
	logic [2:0]            neg_s1;
	logic [2:0][SqW-1:0]   sq_s1;
	logic [2:0][CompW-1:0] raw_in;
	logic [2:0][CompW-1:0] mag_in;
	logic [SumW-1:0]       sum;
	logic                  valid_s2;
	stage_t                stage_s2;

	assign raw_in = {in_z, in_y, in_x};

	// Take magnitudes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_in[i] = raw_in[i][CompW-1] ? (CompW'(0) - raw_in[i]) : raw_in[i];
		end
	end

	// Stage 1: squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= raw_in;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= raw_in[i][CompW-1];
				sq_s1[i]  <= SqW'(mag_in[i]) * SqW'(mag_in[i]);
			end
		end
	end

	assign sum = SumW'(sq_s1[0]) + SumW'(sq_s1[1]) + SumW'(sq_s1[2]);

	// Stage 2: classify and seed the digit search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s2.raw <= raw_s1;
			stage_s2.neg <= neg_s1;
			stage_s2.s   <= sum;
			if (sum == (SumW'(1) << (2 * FracB))) begin
				stage_s2.code <= CodeUnit;
			end else if ((SumW'(sum) < SumW'(tolerance)) || (sum == '0)) begin
				stage_s2.code <= CodeZeroed;
			end else begin
				stage_s2.code <= CodeScaled;
			end
			for (int i = 0; i < 3; i++) begin
				stage_s2.lane[i].q <= '0;
				stage_s2.lane[i].a <= AccW'(sum);
				stage_s2.lane[i].b <= -AccW'(sum);
				stage_s2.lane[i].r <= AccW'(sq_s1[i]) << (2 * FracB + 2);
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_stage = stage_s2;

endmodule

FILE: src/svn_step.sv
module svn_step
	import svn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [BitIdxW-1:0] bit_idx,
	input  logic               in_valid,
	input  stage_t             in_stage,
	output logic               out_valid,
	output stage_t             out_stage
);

	logic                  valid_q;
	stage_t                stage_q;
	stage_t                nxt;
	logic signed [AccW-1:0] a_try;
	logic signed [AccW-1:0] b_try;

	// Try one more digit of q per lane: t grows by 2^(bit+1)
	always_comb begin
		nxt   = in_stage;
		a_try = '0;
		b_try = '0;
		for (int i = 0; i < 3; i++) begin
			a_try = in_stage.lane[i].a
				+ (in_stage.lane[i].b <<< (AccW'(bit_idx) + AccW'(2)))
				+ (AccW'(in_stage.s) << (2 * AccW'(bit_idx) + AccW'(2)));
			b_try = in_stage.lane[i].b + (AccW'(in_stage.s) << (AccW'(bit_idx) + AccW'(1)));
			if (a_try <= in_stage.lane[i].r) begin
				nxt.lane[i].q = in_stage.lane[i].q | (QW'(1) << bit_idx);
				nxt.lane[i].a = a_try;
				nxt.lane[i].b = b_try;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_stage = stage_q;

endmodule

FILE: src/safe_vector3_normalize_core.sv
// Safe 3D vector normalizer, signed Q1.14 in and out.
// in_vec carries one vector per beat; out_norm carries the normalized
// vector and case_code (0 scaled, 1 unit passthrough, 2 zeroed).
// cfg writes the tolerance register (Q4.28 squared length); it is always
// ready and must only be written while the pipeline is empty.
// From input beat to output beat a vector passes two front stages
// (squares, then sum and classify), fifteen stages of the exact rounded
// inverse-root digit search, one bit of the result per stage, and the
// output register.
// Throughput is one vector per cycle while the receiver does not stall; every stage holds one item.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_vec.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets tolerance to 1.
module safe_vector3_normalize_core
	import svn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	svn_vec_if.sink    in_vec,
	svn_norm_if.source out_norm,
	svn_cfg_if.sink    cfg
);

	localparam int NStep = QW;

	logic [TolW-1:0] tolerance_q;
	logic            en;
	logic            out_valid_q;
	logic [2:0][CompW-1:0] norm_q;
	logic [1:0]      code_q;
	logic [NStep:0]  valid_p;
	stage_t          stage_p [NStep+1];
	logic [2:0][CompW-1:0] norm_d;

	// Advance when the output register is free or being taken
	assign en = !out_valid_q || out_norm.ready;
	assign in_vec.ready = en;
	assign cfg.ready = 1'b1;

	// Tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TolReset;
		end else if (cfg.valid) begin
			tolerance_q <= cfg.data;
		end
	end

	svn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_vec.valid),
		.in_x      (in_vec.vec_x),
		.in_y      (in_vec.vec_y),
		.in_z      (in_vec.vec_z),
		.tolerance (tolerance_q),
		.out_valid (valid_p[0]),
		.out_stage (stage_p[0])
	);

	// Digit search, most significant digit first
	for (genvar k = 0; k < NStep; k++) begin : g_step
		svn_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.bit_idx   (BitIdxW'(NStep - 1 - k)),
			.in_valid  (valid_p[k]),
			.in_stage  (stage_p[k]),
			.out_valid (valid_p[k+1]),
			.out_stage (stage_p[k+1])
		);
	end

	// Select result and saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (stage_p[NStep].code == CodeUnit) begin
				norm_d[i] = stage_p[NStep].raw[i];
			end else if (stage_p[NStep].code == CodeZeroed) begin
				norm_d[i] = '0;
			end else if (stage_p[NStep].neg[i]) begin
				if ((CompW+QW)'(stage_p[NStep].lane[i].q) > ((CompW+QW)'(1) << (CompW - 1))) begin
					norm_d[i] = CompW'(1) << (CompW - 1);
				end else begin
					norm_d[i] = CompW'(0) - CompW'(stage_p[NStep].lane[i].q);
				end
			end else begin
				if ((CompW+QW)'(stage_p[NStep].lane[i].q)
						> (((CompW+QW)'(1) << (CompW - 1)) - (CompW+QW)'(1))) begin
					norm_d[i] = (CompW'(1) << (CompW - 1)) - CompW'(1);
				end else begin
					norm_d[i] = CompW'(stage_p[NStep].lane[i].q);
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_p[NStep];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_q <= norm_d;
			code_q <= stage_p[NStep].code;
		end
	end

	assign out_norm.valid     = out_valid_q;
	assign out_norm.norm_x    = norm_q[0];
	assign out_norm.norm_y    = norm_q[1];
	assign out_norm.norm_z    = norm_q[2];
	assign out_norm.case_code = code_q;

endmodule

FILE: src/svn_checker.sv
module svn_checker
	import svn_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CompW-1:0] norm_x,
	input logic [CompW-1:0] norm_y,
	input logic [CompW-1:0] norm_z,
	input logic [1:0]       case_code
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(case_code) && $stable(norm_x))
		else $error("stalled output beat changed");

	// Accept input whenever the output register is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// Never report an unused status code
	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> case_code != 2'd3)
		else $error("illegal case_code");

	// Zeroed results carry the zero vector
	a_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && case_code == CodeZeroed |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
		else $error("zeroed result not zero");

endmodule

bind safe_vector3_normalize_core svn_checker u_svn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_vec.ready),
	.out_valid (out_norm.valid),
	.out_ready (out_norm.ready),
	.norm_x    (out_norm.norm_x),
	.norm_y    (out_norm.norm_y),
	.norm_z    (out_norm.norm_z),
	.case_code (out_norm.case_code)
);

FILE: test/svn_tb_if.sv
`timescale 1ns / 1ps
// Interfaces are defined with the RTL (svn_vec_if, svn_norm_if, svn_cfg_if).
// This file holds the beat record shared by the test.
package svn_tb_pkg;
	import svn_pkg::*;

	typedef struct packed {
		logic signed [CompW-1:0] x;
		logic signed [CompW-1:0] y;
		logic signed [CompW-1:0] z;
		logic [1:0]              code;
	} norm_beat_t;
endpackage

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import svn_pkg::*;
	import svn_tb_pkg::*;

	localparam int Latency = 18;
	localparam int WatchLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	svn_vec_if  in_vec ();
	svn_norm_if out_norm ();
	svn_cfg_if  cfg ();

	safe_vector3_normalize_core dut (
		.clk(clk), .arst_n(arst_n), .in_vec(in_vec), .out_norm(out_norm), .cfg(cfg)
	);

	always #5 clk = ~clk;

	logic [TolW-1:0] tol_reg;
	norm_beat_t      norm_queue[$];
	int              mismatches = 0;
	int              vec_count = 0;
	int              norm_count = 0;
	int              idle_cycles = 0;
	bit              sender_gaps = 1'b1;
	bit              sink_gaps = 1'b1;
	int              hold_off = 0;
	int              hold_req = 0;
	int              hold_ack = 0;
	int              code_seen[3] = '{0, 0, 0};

	// Largest q in [0, 2^F] with q - 1/2 <= mag * 2^F / sqrt(s)
	function automatic logic [QW-1:0] root_digits(logic [CompW-1:0] mag, logic [SumW-1:0] s);
		logic [127:0] rhs;
		logic [127:0] lhs;
		logic [63:0]  t;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = 0;
		hi = 64'd1 << FracB;
		rhs = (128'(mag) * 128'(mag)) << (2 * FracB + 2);
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			t = 2 * mid - 1;
			lhs = 128'(t * t) * 128'(s);
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return QW'(lo);
	endfunction

	function automatic norm_beat_t normalize(logic signed [CompW-1:0] vx,
			logic signed [CompW-1:0] vy, logic signed [CompW-1:0] vz);
		norm_beat_t r;
		logic signed [CompW-1:0] v[3];
		logic [CompW-1:0] mag[3];
		logic signed [CompW-1:0] o[3];
		logic [SumW-1:0] s;
		longint q;
		v = '{vx, vy, vz};
		s = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i][CompW-1] ? CompW'(-v[i]) : v[i];
			s += SumW'(mag[i]) * SumW'(mag[i]);
		end
		if (s == (SumW'(1) << (2 * FracB))) begin
			r = '{vx, vy, vz, CodeUnit};
		end else if (s < tol_reg || s == 0) begin
			r = '{'0, '0, '0, CodeZeroed};
		end else begin
			for (int i = 0; i < 3; i++) begin
				q = root_digits(mag[i], s);
				if (v[i][CompW-1]) begin
					if (q > (64'd1 << (CompW - 1))) q = 64'd1 << (CompW - 1);
					o[i] = CompW'(-q);
				end else begin
					if (q > (64'd1 << (CompW - 1)) - 1) q = (64'd1 << (CompW - 1)) - 1;
					o[i] = CompW'(q);
				end
			end
			r = '{o[0], o[1], o[2], CodeScaled};
		end
		return r;
	endfunction

	// Send one vector, predicting its result on acceptance
	task automatic send_vec(logic signed [CompW-1:0] vx, logic signed [CompW-1:0] vy,
			logic signed [CompW-1:0] vz);
		int gap;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			in_vec.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_vec.valid <= 1'b1;
		in_vec.vec_x <= vx;
		in_vec.vec_y <= vy;
		in_vec.vec_z <= vz;
		do @(posedge clk); while (!in_vec.ready);
		norm_queue.push_back(normalize(vx, vy, vz));
		vec_count++;
	endtask

	task automatic drain();
		in_vec.valid <= 1'b0;
		while (norm_queue.size() != 0) @(posedge clk);
		repeat (Latency + 2) @(posedge clk);
	endtask

	task automatic write_tol(logic [TolW-1:0] value);
		drain();
		cfg.valid <= 1'b1;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		tol_reg = value;
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [CompW-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return CompW'($urandom_range(0, 64)) - 16'sd32;
			3: return CompW'($urandom_range(0, 32768)) - 16'sd16384;
			default: return CompW'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_vec(0, 0, 0);
		send_vec(16384, 0, 0);
		send_vec(0, -16384, 0);
		send_vec(0, 0, 16384);
		send_vec(16'sh8000, 16'sh8000, 16'sh8000);
		send_vec(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_vec(16'sh8000, 0, 0);
		send_vec(16'sh7fff, 0, 0);
		send_vec(1, 0, 0);
		send_vec(-1, -1, -1);
		send_vec(16384, 1, 0);
		send_vec(8192, 8192, 8192);
		send_vec(-9459, 9459, -9459);
		send_vec(16'sh7fff, 16'sh8000, 1);
		// near-unit vector from a Pythagorean split: 0.6, 0.8 scaled by 2^14 is not exact, so keep near
		send_vec(9830, 13107, 0);
	endtask

	task automatic test_tolerance();
		write_tol('0);
		send_vec(0, 0, 0);
		send_vec(1, 0, 0);
		send_vec(0, 0, -1);
		write_tol(32'hC000_0000);
		send_vec(16384, 0, 0);
		send_vec(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_vec(16'sh8000, 16'sh8000, 16'sh8000);
		send_vec(20000, 0, 0);
		write_tol(32'h1000_0000);
		send_vec(16383, 0, 0);
		send_vec(16385, 0, 0);
		send_vec(16384, 0, 0);
	endtask

	task automatic test_random(int n, logic [TolW-1:0] tol);
		write_tol(tol);
		repeat (n) send_vec(rand_comp(), rand_comp(), rand_comp());
	endtask

	// Long receiver hold while the sender keeps offering
	task automatic test_backpressure();
		drain();
		sender_gaps = 1'b0;
		hold_req++;
		repeat (60) send_vec(rand_comp(), rand_comp(), rand_comp());
		sender_gaps = 1'b1;
		drain();
	endtask

	// Sink side: random stalls, long hold when asked
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			out_norm.ready <= 1'b0;
			hold_off <= 199;
			hold_ack <= hold_req;
		end else if (hold_off > 0) begin
			out_norm.ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
			out_norm.ready <= 1'b0;
			hold_off <= $urandom_range(0, 8);
		end else begin
			out_norm.ready <= 1'b1;
		end
	end

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin
		norm_beat_t want;
		norm_beat_t got;
		if (arst_n && out_norm.valid && out_norm.ready) begin
			got = '{out_norm.norm_x, out_norm.norm_y, out_norm.norm_z, out_norm.case_code};
			norm_count++;
			if (norm_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
			end else begin
				want = norm_queue.pop_front();
				if (got.code <= 2) code_seen[got.code]++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %0d %0d code %0d, got %0d %0d %0d code %0d",
							want.x, want.y, want.z, want.code, got.x, got.y, got.z, got.code);
				end
			end
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_vec.valid && in_vec.ready) || (out_norm.valid && out_norm.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		in_vec.valid = 1'b0;
		in_vec.vec_x = '0;
		in_vec.vec_y = '0;
		in_vec.vec_z = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		tol_reg = TolReset;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_tolerance();
		test_random(400, 32'd1);
		test_backpressure();
		test_random(300, 32'h0100_0000);
		test_random(200, '0);
		// last stretch runs at full rate on both sides
		sender_gaps = 1'b0;
		sink_gaps = 1'b0;
		test_random(300, 32'd1);
		drain();
		$display("Sent %0d vectors, checked %0d results (scaled %0d, unit %0d, zeroed %0d).",
			vec_count, norm_count, code_seen[0], code_seen[1], code_seen[2]);
		if (mismatches == 0 && norm_queue.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
